[rtl/lob_pkg.sv]
// shared types, codes and defaults for the limit order book
`timescale 1ns / 1ps
`default_nettype none
package lob_pkg;

	localparam int PRICE_BITS   = 20;
	localparam int QTY_BITS     = 24;
	localparam int ID_BITS      = 32;
	localparam int TOTAL_BITS   = 34;
	localparam int COUNT_BITS   = 11;
	localparam int MAX_ORDERS_D = 1024;
	localparam int MAX_LEVELS_D = 256;
	localparam int MAX_DEPTH_D  = 16;

	localparam logic [2:0] ACT_ADD    = 3'd0;
	localparam logic [2:0] ACT_CANCEL = 3'd1;
	localparam logic [2:0] ACT_RM_BID = 3'd2;
	localparam logic [2:0] ACT_RM_ASK = 3'd3;
	localparam logic [2:0] ACT_RD_BID = 3'd4;
	localparam logic [2:0] ACT_RD_ASK = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_DUP       = 3'd4;

	typedef struct packed {
		logic [2:0]            action;
		logic [ID_BITS-1:0]    order_id;
		logic                  side;
		logic [PRICE_BITS-1:0] price;
		logic [QTY_BITS-1:0]   quantity;
		logic [4:0]            depth;
	} req_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [PRICE_BITS-1:0] best_bid_price;
		logic [PRICE_BITS-1:0] best_ask_price;
		logic [PRICE_BITS-1:0] spread_ticks;
		logic [ID_BITS-1:0]    best_bid_order;
		logic [QTY_BITS-1:0]   best_bid_qty;
		logic [ID_BITS-1:0]    best_ask_order;
		logic [QTY_BITS-1:0]   best_ask_qty;
		logic [PRICE_BITS-1:0] level_price;
		logic [TOTAL_BITS-1:0] level_total;
		logic [COUNT_BITS-1:0] level_count;
		logic                  last;
	} rsp_t;

endpackage
`default_nettype wire

[rtl/lob_if.sv]
// valid/ready stream interface carrying one word
`timescale 1ns / 1ps
`default_nettype none
interface lob_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/limit_order_book.sv]
// limit order book top level with result output register
//
//   port  dir  word   content
//   req   in   req_t  action, order id, side, price, quantity, depth
//   rsp   out  rsp_t  status, best of book, one level report, last
//
// one item at a time; an id search reads every order slot,
// then the level walk, level shifts and fifo walks step through their entries.
// a read walks each reported level and every resting order on it.
// after reset the order store is cleared slot by slot, req.ready low.
// a result waiting in the output register does not stop the next word
`timescale 1ns / 1ps
`default_nettype none
module limit_order_book #(
	parameter int MAX_ORDERS = lob_pkg::MAX_ORDERS_D,
	parameter int MAX_LEVELS = lob_pkg::MAX_LEVELS_D,
	parameter int MAX_DEPTH  = lob_pkg::MAX_DEPTH_D
) (
	input wire logic clk,
	input wire logic arst_n,
	lob_if.sink      req,
	lob_if.source    rsp
);
	import lob_pkg::*;

	logic emit_valid;
	logic emit_take;
	rsp_t emit_data;
	logic ov_q;
	rsp_t od_q;

	lob_ctrl #(
		.MAX_ORDERS (MAX_ORDERS),
		.MAX_LEVELS (MAX_LEVELS),
		.MAX_DEPTH  (MAX_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_data   (req.data),
		.req_ready  (req.ready),
		.emit_valid (emit_valid),
		.emit_data  (emit_data),
		.emit_take  (emit_take)
	);

	assign emit_take = !ov_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit_take) begin
			ov_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid && emit_take) begin
			od_q <= emit_data;
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.data  = od_q;

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && emit_take |=> ov_q)
		else $error("taken result not in output register");

	a_idle_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !emit_valid)
		else $error("word accepted while a result is pending");

	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid && !emit_take |=> emit_valid && $stable(emit_data))
		else $error("stalled result dropped or changed");
endmodule
`default_nettype wire

[rtl/lob_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module lob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/lob_ctrl.sv]
// sequencer over the order store and the price level tables
`timescale 1ns / 1ps
`default_nettype none
module lob_ctrl #(
	parameter int MAX_ORDERS = lob_pkg::MAX_ORDERS_D,
	parameter int MAX_LEVELS = lob_pkg::MAX_LEVELS_D,
	parameter int MAX_DEPTH  = lob_pkg::MAX_DEPTH_D
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire lob_pkg::req_t req_data,
	output logic               req_ready,
	output logic               emit_valid,
	output lob_pkg::rsp_t      emit_data,
	input  wire logic          emit_take
);
	import lob_pkg::*;

	localparam int OW  = $clog2(MAX_ORDERS);
	localparam int SW  = $clog2(MAX_ORDERS + 1);
	localparam int LW  = $clog2(MAX_LEVELS);
	localparam int LCW = $clog2(MAX_LEVELS + 1);
	localparam logic [SW-1:0]  NO_SLOT = SW'(MAX_ORDERS);
	localparam logic [LCW-1:0] LV_MAX  = LCW'(MAX_LEVELS);

	typedef struct packed {
		logic                  vld;
		logic [ID_BITS-1:0]    id;
		logic                  sd;
		logic [PRICE_BITS-1:0] price;
		logic [QTY_BITS-1:0]   qty;
		logic [SW-1:0]         nxt;
	} ord_t;

	typedef struct packed {
		logic [PRICE_BITS-1:0] price;
		logic [SW-1:0]         head;
		logic [SW-1:0]         tail;
	} lvl_t;

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_SCAN  = 5'd2;
	localparam logic [4:0] S_DEC   = 5'd3;
	localparam logic [4:0] S_LVL   = 5'd4;
	localparam logic [4:0] S_SHUP  = 5'd5;
	localparam logic [4:0] S_INS   = 5'd6;
	localparam logic [4:0] S_TREAD = 5'd7;
	localparam logic [4:0] S_OWR   = 5'd8;
	localparam logic [4:0] S_INV   = 5'd9;
	localparam logic [4:0] S_RMV   = 5'd10;
	localparam logic [4:0] S_ULNK  = 5'd11;
	localparam logic [4:0] S_UFIX  = 5'd12;
	localparam logic [4:0] S_UFIX2 = 5'd13;
	localparam logic [4:0] S_ULV   = 5'd14;
	localparam logic [4:0] S_SHDN  = 5'd15;
	localparam logic [4:0] S_REFL  = 5'd16;
	localparam logic [4:0] S_REFO  = 5'd17;
	localparam logic [4:0] S_RLV   = 5'd18;
	localparam logic [4:0] S_RWALK = 5'd19;
	localparam logic [4:0] S_EMIT  = 5'd20;

	logic [4:0]            state_q;
	logic                  ph_q;
	logic [2:0]            act_q;
	logic                  s_q;
	logic [ID_BITS-1:0]    id_q;
	logic [PRICE_BITS-1:0] price_q;
	logic [QTY_BITS-1:0]   qty_q;
	logic [2:0]            sts_q;
	logic [SW-1:0]         oc_q;
	logic [LCW-1:0]        lc_q;
	logic [LCW-1:0]        li_q;
	logic [LCW-1:0]        rep_n_q;
	logic                  found_q;
	logic                  free_q;
	logic [OW-1:0]         free_slot_q;
	logic [OW-1:0]         tslot_q;
	ord_t                  tword_q;
	logic [SW-1:0]         prev_q;
	ord_t                  prevword_q;
	lvl_t                  lvword_q;
	logic [PRICE_BITS-1:0] rep_price_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [SW-1:0]         cnt_q;
	logic                  last_q;
	logic [LCW-1:0]        n_lev_q [2];
	logic [PRICE_BITS-1:0] bp_q [2];
	logic [ID_BITS-1:0]    bo_q [2];
	logic [QTY_BITS-1:0]   bqt_q [2];

	logic                  ord_we;
	logic [OW-1:0]         ord_wa;
	ord_t                  ord_wd;
	ord_t                  ord_rd;
	logic                  lvl_we;
	logic [LW:0]           lvl_wa;
	lvl_t                  lvl_wd;
	lvl_t                  lvl_rd;
	logic [LCW-1:0]        lidx;
	logic [LW:0]           lvl_ra;

	logic                  acc;
	logic                  rd_side;
	logic [31:0]           dsat;
	logic [31:0]           nrep;
	logic                  is_add;
	logic                  better;
	ord_t                  new_ord;

	lob_ram #(.WIDTH($bits(ord_t)), .DEPTH(MAX_ORDERS)) u_ord_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_wa),
		.wdata (ord_wd),
		.raddr (oc_q[OW-1:0]),
		.rdata (ord_rd)
	);

	lob_ram #(.WIDTH($bits(lvl_t)), .DEPTH(2 * MAX_LEVELS)) u_lvl_ram (
		.clk   (clk),
		.we    (lvl_we),
		.waddr (lvl_wa),
		.wdata (lvl_wd),
		.raddr (lvl_ra),
		.rdata (lvl_rd)
	);

	assign req_ready = (state_q == S_IDLE);
	assign acc       = req_valid && req_ready;
	assign rd_side   = (req_data.action == ACT_RD_ASK);
	assign dsat      = (32'(req_data.depth) > MAX_DEPTH) ? 32'(MAX_DEPTH) : 32'(req_data.depth);
	assign nrep      = (dsat > 32'(n_lev_q[rd_side])) ? 32'(n_lev_q[rd_side]) : dsat;
	assign is_add    = (act_q == ACT_ADD);
	assign better    = s_q ? (price_q < lvl_rd.price) : (price_q > lvl_rd.price);

	always_comb begin
		new_ord.vld   = 1'b1;
		new_ord.id    = id_q;
		new_ord.sd    = s_q;
		new_ord.price = price_q;
		new_ord.qty   = qty_q;
		new_ord.nxt   = NO_SLOT;
	end

	// shifts read the neighbour of the entry they write
	always_comb begin
		case (state_q)
			S_SHUP:  lidx = lc_q - LCW'(1);
			S_SHDN:  lidx = lc_q + LCW'(1);
			default: lidx = lc_q;
		endcase
		lvl_ra = {s_q, lidx[LW-1:0]};
	end

	always_comb begin
		ord_we = 1'b0;
		ord_wa = tslot_q;
		ord_wd = tword_q;
		ord_wd.vld = 1'b0;
		lvl_we = 1'b0;
		lvl_wa = {s_q, lc_q[LW-1:0]};
		lvl_wd = lvword_q;
		case (state_q)
			S_CLR: begin
				ord_we = 1'b1;
				ord_wa = oc_q[OW-1:0];
				ord_wd = '0;
				ord_wd.nxt = NO_SLOT;
			end
			S_SHUP: begin
				lvl_we = ph_q;
				lvl_wd = lvl_rd;
			end
			S_SHDN: begin
				lvl_we = ph_q;
				lvl_wd = lvl_rd;
			end
			S_INS: begin
				lvl_we = 1'b1;
				lvl_wa = {s_q, li_q[LW-1:0]};
				lvl_wd.price = price_q;
				lvl_wd.head  = SW'(free_slot_q);
				lvl_wd.tail  = SW'(free_slot_q);
				ord_we = 1'b1;
				ord_wa = free_slot_q;
				ord_wd = new_ord;
			end
			S_TREAD: begin
				ord_we = ph_q;
				ord_wa = oc_q[OW-1:0];
				ord_wd = ord_rd;
				ord_wd.nxt = SW'(free_slot_q);
				lvl_we = ph_q;
				lvl_wa = {s_q, li_q[LW-1:0]};
				lvl_wd.tail = SW'(free_slot_q);
			end
			S_OWR: begin
				ord_we = 1'b1;
				ord_wa = free_slot_q;
				ord_wd = new_ord;
			end
			S_INV, S_UFIX: begin
				ord_we = 1'b1;
			end
			S_UFIX2: begin
				ord_we = 1'b1;
				ord_wa = prev_q[OW-1:0];
				ord_wd = prevword_q;
				ord_wd.nxt = tword_q.nxt;
			end
			S_ULV: begin
				lvl_we = (lvword_q.head != NO_SLOT);
				lvl_wa = {s_q, li_q[LW-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			ph_q       <= 1'b0;
			oc_q       <= '0;
			n_lev_q[0] <= '0;
			n_lev_q[1] <= '0;
			bp_q[0]    <= '0;
			bp_q[1]    <= '0;
			bo_q[0]    <= '0;
			bo_q[1]    <= '0;
			bqt_q[0]   <= '0;
			bqt_q[1]   <= '0;
			sts_q      <= ST_OK;
			last_q     <= 1'b1;
		end else begin
			case (state_q)
				S_CLR: begin
					oc_q <= oc_q + SW'(1);
					if (oc_q == SW'(MAX_ORDERS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						act_q       <= req_data.action;
						id_q        <= req_data.order_id;
						price_q     <= req_data.price;
						qty_q       <= req_data.quantity;
						ph_q        <= 1'b0;
						oc_q        <= '0;
						lc_q        <= '0;
						found_q     <= 1'b0;
						free_q      <= 1'b0;
						rep_price_q <= '0;
						total_q     <= '0;
						cnt_q       <= '0;
						case (req_data.action)
							ACT_ADD, ACT_CANCEL: begin
								s_q     <= req_data.side;
								sts_q   <= ST_OK;
								last_q  <= 1'b1;
								state_q <= S_SCAN;
							end
							ACT_RM_BID, ACT_RM_ASK: begin
								s_q    <= (req_data.action == ACT_RM_ASK);
								last_q <= 1'b1;
								if (n_lev_q[req_data.action == ACT_RM_ASK] == '0) begin
									sts_q   <= ST_EMPTY;
									state_q <= S_EMIT;
								end else begin
									sts_q   <= ST_OK;
									state_q <= S_RMV;
								end
							end
							ACT_RD_BID, ACT_RD_ASK: begin
								s_q     <= rd_side;
								rep_n_q <= LCW'(nrep);
								if (nrep == 32'd0) begin
									sts_q   <= (n_lev_q[rd_side] == '0) ? ST_EMPTY : ST_OK;
									last_q  <= 1'b1;
									state_q <= S_EMIT;
								end else begin
									sts_q   <= ST_OK;
									last_q  <= 1'b0;
									state_q <= S_RLV;
								end
							end
							default: begin
								s_q     <= req_data.side;
								sts_q   <= ST_OK;
								last_q  <= 1'b1;
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				// id search over every slot, first free slot noted on the way
				S_SCAN: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (ord_rd.vld && ord_rd.id == id_q) begin
							found_q <= 1'b1;
							tslot_q <= oc_q[OW-1:0];
							tword_q <= ord_rd;
						end
						if (!ord_rd.vld && !free_q) begin
							free_q      <= 1'b1;
							free_slot_q <= oc_q[OW-1:0];
						end
						if (oc_q == SW'(MAX_ORDERS - 1)) begin
							state_q <= S_DEC;
						end else begin
							oc_q <= oc_q + SW'(1);
						end
					end
				end
				S_DEC: begin
					lc_q <= '0;
					ph_q <= 1'b0;
					if (is_add) begin
						if (found_q || !free_q) begin
							sts_q   <= found_q ? ST_DUP : ST_FULL;
							s_q     <= 1'b0;
							state_q <= S_REFL;
						end else begin
							state_q <= S_LVL;
						end
					end else if (!found_q) begin
						sts_q   <= ST_NOT_FOUND;
						s_q     <= 1'b0;
						state_q <= S_REFL;
					end else begin
						s_q     <= tword_q.sd;
						price_q <= tword_q.price;
						state_q <= S_LVL;
					end
				end
				// walk the side from its best level for the price
				S_LVL: begin
					if (!ph_q) begin
						if (lc_q == n_lev_q[s_q]) begin
							li_q <= lc_q;
							if (!is_add) begin
								state_q <= S_INV;
							end else if (n_lev_q[s_q] == LV_MAX) begin
								sts_q   <= ST_FULL;
								s_q     <= 1'b0;
								lc_q    <= '0;
								state_q <= S_REFL;
							end else begin
								state_q <= S_SHUP;
							end
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						if (lvl_rd.price == price_q) begin
							li_q     <= lc_q;
							lvword_q <= lvl_rd;
							if (is_add) begin
								oc_q    <= lvl_rd.tail;
								state_q <= S_TREAD;
							end else begin
								oc_q    <= lvl_rd.head;
								prev_q  <= NO_SLOT;
								state_q <= S_ULNK;
							end
						end else if (is_add && better) begin
							li_q <= lc_q;
							if (n_lev_q[s_q] == LV_MAX) begin
								sts_q   <= ST_FULL;
								s_q     <= 1'b0;
								lc_q    <= '0;
								state_q <= S_REFL;
							end else begin
								lc_q    <= n_lev_q[s_q];
								state_q <= S_SHUP;
							end
						end else begin
							lc_q <= lc_q + LCW'(1);
						end
					end
				end
				// open a gap at the insert position, worst level first
				S_SHUP: begin
					if (!ph_q) begin
						if (lc_q == li_q) begin
							state_q <= S_INS;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						lc_q <= lc_q - LCW'(1);
					end
				end
				S_INS: begin
					n_lev_q[s_q] <= n_lev_q[s_q] + LCW'(1);
					s_q          <= 1'b0;
					lc_q         <= '0;
					state_q      <= S_REFL;
				end
				S_TREAD: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q    <= 1'b0;
						state_q <= S_OWR;
					end
				end
				S_OWR, S_INV: begin
					s_q     <= 1'b0;
					lc_q    <= '0;
					state_q <= S_REFL;
				end
				S_RMV: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q     <= 1'b0;
						lvword_q <= lvl_rd;
						li_q     <= '0;
						tslot_q  <= lvl_rd.head[OW-1:0];
						oc_q     <= lvl_rd.head;
						prev_q   <= NO_SLOT;
						state_q  <= S_ULNK;
					end
				end
				// find the order in its fifo, keeping its predecessor
				S_ULNK: begin
					if (oc_q == NO_SLOT) begin
						state_q <= S_INV;
					end else if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (oc_q == SW'(tslot_q)) begin
							tword_q <= ord_rd;
							state_q <= S_UFIX;
						end else begin
							prev_q     <= oc_q;
							prevword_q <= ord_rd;
							oc_q       <= ord_rd.nxt;
						end
					end
				end
				S_UFIX: begin
					if (prev_q == NO_SLOT) begin
						lvword_q.head <= tword_q.nxt;
					end
					if (lvword_q.tail == SW'(tslot_q)) begin
						lvword_q.tail <= prev_q;
					end
					state_q <= (prev_q != NO_SLOT) ? S_UFIX2 : S_ULV;
				end
				S_UFIX2: begin
					state_q <= S_ULV;
				end
				S_ULV: begin
					ph_q <= 1'b0;
					if (lvword_q.head == NO_SLOT) begin
						lc_q    <= li_q;
						state_q <= S_SHDN;
					end else begin
						s_q     <= 1'b0;
						lc_q    <= '0;
						state_q <= S_REFL;
					end
				end
				// close the gap of a deleted level
				S_SHDN: begin
					if (!ph_q) begin
						if (lc_q + LCW'(1) >= n_lev_q[s_q]) begin
							n_lev_q[s_q] <= n_lev_q[s_q] - LCW'(1);
							s_q          <= 1'b0;
							lc_q         <= '0;
							state_q      <= S_REFL;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						lc_q <= lc_q + LCW'(1);
					end
				end
				// refresh best price and front order of both sides
				S_REFL: begin
					if (n_lev_q[s_q] == '0) begin
						bp_q[s_q]  <= '0;
						bo_q[s_q]  <= '0;
						bqt_q[s_q] <= '0;
						ph_q       <= 1'b0;
						s_q        <= 1'b1;
						state_q    <= s_q ? S_EMIT : S_REFL;
					end else if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q      <= 1'b0;
						bp_q[s_q] <= lvl_rd.price;
						oc_q      <= lvl_rd.head;
						state_q   <= S_REFO;
					end
				end
				S_REFO: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q       <= 1'b0;
						bo_q[s_q]  <= ord_rd.id;
						bqt_q[s_q] <= ord_rd.qty;
						s_q        <= 1'b1;
						state_q    <= s_q ? S_EMIT : S_REFL;
					end
				end
				S_RLV: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q        <= 1'b0;
						rep_price_q <= lvl_rd.price;
						oc_q        <= lvl_rd.head;
						total_q     <= '0;
						cnt_q       <= '0;
						state_q     <= S_RWALK;
					end
				end
				S_RWALK: begin
					if (oc_q == NO_SLOT) begin
						last_q  <= (lc_q + LCW'(1) == rep_n_q);
						state_q <= S_EMIT;
					end else if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q    <= 1'b0;
						total_q <= total_q + TOTAL_BITS'(ord_rd.qty);
						cnt_q   <= cnt_q + SW'(1);
						oc_q    <= ord_rd.nxt;
					end
				end
				S_EMIT: begin
					if (emit_take) begin
						ph_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							lc_q    <= lc_q + LCW'(1);
							state_q <= S_RLV;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign emit_valid = (state_q == S_EMIT);

	always_comb begin
		emit_data.status         = sts_q;
		emit_data.best_bid_price = bp_q[0];
		emit_data.best_ask_price = bp_q[1];
		emit_data.spread_ticks   = (bp_q[0] != '0 && bp_q[1] > bp_q[0]) ? bp_q[1] - bp_q[0] : '0;
		emit_data.best_bid_order = bo_q[0];
		emit_data.best_bid_qty   = bqt_q[0];
		emit_data.best_ask_order = bo_q[1];
		emit_data.best_ask_qty   = bqt_q[1];
		emit_data.level_price    = rep_price_q;
		emit_data.level_total    = total_q;
		emit_data.level_count    = COUNT_BITS'(cnt_q);
		emit_data.last           = last_q;
	end
endmodule
`default_nettype wire

[bench/tb_top.sv]
// self-checking bench for the limit order book: directed table then random orders
`timescale 1ns / 1ps
module tb_top;
	import lob_pkg::*;

	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;
	localparam int N_RANDOM  = 136;
	localparam int CYC_LIMIT = 3000000;
	localparam int DRAIN     = 3000;

	typedef struct {
		logic [ID_BITS-1:0]    id;
		logic                  side;
		logic [PRICE_BITS-1:0] price;
		logic [QTY_BITS-1:0]   qty;
	} resting_t;

	typedef struct {
		req_t       word;
		logic       typed;
		logic [2:0] st;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	int   cycles = 0;
	int   errors = 0;
	int   tx_idle = 19;
	int   rx_idle = 52;

	lob_if #(.T(req_t)) req_if ();
	lob_if #(.T(rsp_t)) rsp_if ();

	limit_order_book DUT (.clk(clk), .arst_n(arst_n), .req(req_if.sink), .rsp(rsp_if.source));

	always #4 clk = ~clk;

	// book image: resting orders in arrival order, sorted level prices per side
	resting_t resting[$];
	logic [PRICE_BITS-1:0] bid_lvls[$];
	logic [PRICE_BITS-1:0] ask_lvls[$];
	rsp_t expected_rsp[$];
	logic [ID_BITS-1:0] used_ids[$];

	function automatic int n_levels(logic s);
		return s ? ask_lvls.size() : bid_lvls.size();
	endfunction

	function automatic logic [PRICE_BITS-1:0] lvl_at(logic s, int k);
		return s ? ask_lvls[k] : bid_lvls[k];
	endfunction

	function automatic int find_id(logic [ID_BITS-1:0] id);
		foreach (resting[i])
			if (resting[i].id == id)
				return i;
		return -1;
	endfunction

	function automatic int level_orders(logic s, logic [PRICE_BITS-1:0] p);
		int n;
		n = 0;
		foreach (resting[i])
			if (resting[i].side == s && resting[i].price == p)
				n++;
		return n;
	endfunction

	function automatic void drop_level_if_empty(logic s, logic [PRICE_BITS-1:0] p);
		if (level_orders(s, p) != 0)
			return;
		if (s) begin
			foreach (ask_lvls[k])
				if (ask_lvls[k] == p) begin
					ask_lvls.delete(k);
					return;
				end
		end else begin
			foreach (bid_lvls[k])
				if (bid_lvls[k] == p) begin
					bid_lvls.delete(k);
					return;
				end
		end
	endfunction

	function automatic rsp_t book_word(logic [2:0] st, logic [PRICE_BITS-1:0] lp,
			logic [TOTAL_BITS-1:0] lt, logic [COUNT_BITS-1:0] lc, logic lst);
		rsp_t w;
		int   bi, ai;
		w = '0;
		bi = -1;
		ai = -1;
		if (bid_lvls.size() > 0) begin
			w.best_bid_price = bid_lvls[0];
			foreach (resting[i])
				if (bi < 0 && !resting[i].side && resting[i].price == bid_lvls[0])
					bi = i;
		end
		if (ask_lvls.size() > 0) begin
			w.best_ask_price = ask_lvls[0];
			foreach (resting[i])
				if (ai < 0 && resting[i].side && resting[i].price == ask_lvls[0])
					ai = i;
		end
		if (bi >= 0) begin
			w.best_bid_order = resting[bi].id;
			w.best_bid_qty   = resting[bi].qty;
		end
		if (ai >= 0) begin
			w.best_ask_order = resting[ai].id;
			w.best_ask_qty   = resting[ai].qty;
		end
		if (w.best_bid_price > 0 && w.best_ask_price > w.best_bid_price)
			w.spread_ticks = w.best_ask_price - w.best_bid_price;
		w.status      = st;
		w.level_price = lp;
		w.level_total = lt;
		w.level_count = lc;
		w.last        = lst;
		return w;
	endfunction

	function automatic logic [2:0] book_add(req_t r);
		resting_t o;
		int       pos;
		logic     fresh;
		if (find_id(r.order_id) >= 0)
			return ST_DUP;
		if (resting.size() >= MAX_ORDERS_D)
			return ST_FULL;
		fresh = 1;
		for (int k = 0; k < n_levels(r.side); k++)
			if (lvl_at(r.side, k) == r.price)
				fresh = 0;
		if (fresh) begin
			if (n_levels(r.side) >= MAX_LEVELS_D)
				return ST_FULL;
			pos = 0;
			while (pos < n_levels(r.side) && !(r.side ? r.price < lvl_at(r.side, pos)
					: r.price > lvl_at(r.side, pos)))
				pos++;
			if (r.side)
				ask_lvls.insert(pos, r.price);
			else
				bid_lvls.insert(pos, r.price);
		end
		o.id    = r.order_id;
		o.side  = r.side;
		o.price = r.price;
		o.qty   = r.quantity;
		resting = {resting, o};
		return ST_OK;
	endfunction

	// works out every result word of one request and queues them
	function automatic void predict_book(req_t r, logic typed, logic [2:0] typed_st);
		logic [2:0]            st;
		int                    idx, n;
		logic                  s;
		logic [PRICE_BITS-1:0] p;
		logic [TOTAL_BITS-1:0] tot;
		logic [COUNT_BITS-1:0] cnt;
		rsp_t                  w;
		st = ST_OK;
		case (r.action)
			ACT_ADD: st = book_add(r);
			ACT_CANCEL: begin
				idx = find_id(r.order_id);
				if (idx < 0)
					st = ST_NOT_FOUND;
				else begin
					s = resting[idx].side;
					p = resting[idx].price;
					resting.delete(idx);
					drop_level_if_empty(s, p);
				end
			end
			ACT_RM_BID, ACT_RM_ASK: begin
				s = (r.action == ACT_RM_ASK);
				if (n_levels(s) == 0)
					st = ST_EMPTY;
				else begin
					p = lvl_at(s, 0);
					idx = -1;
					foreach (resting[i])
						if (idx < 0 && resting[i].side == s && resting[i].price == p)
							idx = i;
					resting.delete(idx);
					drop_level_if_empty(s, p);
				end
			end
			ACT_RD_BID, ACT_RD_ASK: begin
				s = (r.action == ACT_RD_ASK);
				n = (r.depth > MAX_DEPTH_D) ? MAX_DEPTH_D : r.depth;
				if (n > n_levels(s))
					n = n_levels(s);
				if (n == 0)
					st = (n_levels(s) == 0) ? ST_EMPTY : ST_OK;
				else begin
					for (int k = 0; k < n; k++) begin
						p = lvl_at(s, k);
						tot = '0;
						cnt = '0;
						foreach (resting[i])
							if (resting[i].side == s && resting[i].price == p) begin
								tot += resting[i].qty;
								cnt++;
							end
						w = book_word(ST_OK, p, tot, cnt, k == n - 1);
						if (typed && k == 0)
							w.status = typed_st;
						expected_rsp = {expected_rsp, w};
					end
					return;
				end
			end
			default: st = ST_OK;
		endcase
		w = book_word(st, '0, '0, '0, 1'b1);
		if (typed)
			w.status = typed_st;
		expected_rsp = {expected_rsp, w};
	endfunction

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_t e, a;
		cycles <= cycles + 1;
		rsp_if.ready <= ($urandom_range(99) >= rx_idle);
		if (rsp_if.valid && rsp_if.ready) begin
			a = rsp_if.data;
			if (expected_rsp.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = expected_rsp[0];
				expected_rsp.delete(0);
				check_field("status", e.status, a.status);
				check_field("best_bid_price", e.best_bid_price, a.best_bid_price);
				check_field("best_ask_price", e.best_ask_price, a.best_ask_price);
				check_field("spread_ticks", e.spread_ticks, a.spread_ticks);
				check_field("best_bid_order", e.best_bid_order, a.best_bid_order);
				check_field("best_bid_qty", e.best_bid_qty, a.best_bid_qty);
				check_field("best_ask_order", e.best_ask_order, a.best_ask_order);
				check_field("best_ask_qty", e.best_ask_qty, a.best_ask_qty);
				check_field("level_price", e.level_price, a.level_price);
				check_field("level_total", e.level_total, a.level_total);
				check_field("level_count", e.level_count, a.level_count);
				check_field("last", e.last, a.last);
			end
		end
		if (cycles > CYC_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_word(req_t r, logic typed, logic [2:0] typed_st);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle)
			gap++;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= r;
		do
			@(posedge clk);
		while (!req_if.ready);
		predict_book(r, typed, typed_st);
	endtask

	function automatic req_t mk(logic [2:0] act, logic [31:0] id, logic sd,
			logic [19:0] pr, logic [23:0] q, logic [4:0] dp);
		req_t r;
		r.action   = act;
		r.order_id = id;
		r.side     = sd;
		r.price    = pr;
		r.quantity = q;
		r.depth    = dp;
		return r;
	endfunction

	function automatic req_t random_word();
		req_t r;
		int   pick;
		r = mk(3'($urandom_range(7)), $urandom, 1'($urandom), 20'($urandom),
			24'($urandom), 5'($urandom_range(31)));
		pick = $urandom_range(99);
		if (pick < 45)
			r.action = ACT_ADD;
		else if (pick < 62)
			r.action = ACT_CANCEL;
		else if (pick < 70)
			r.action = ACT_RM_BID;
		else if (pick < 78)
			r.action = ACT_RM_ASK;
		else if (pick < 87)
			r.action = ACT_RD_BID;
		else if (pick < 96)
			r.action = ACT_RD_ASK;
		// reuse known ids so cancels hit and duplicates happen
		if (used_ids.size() > 0 && $urandom_range(99) < (r.action == ACT_CANCEL ? 80 : 15))
			r.order_id = used_ids[$urandom_range(used_ids.size() - 1)];
		else if ($urandom_range(3) == 0)
			r.order_id = $urandom_range(31);
		// a handful of nearby levels most of the time
		if ($urandom_range(9) != 0)
			r.price = 20'd1000 + 20'($urandom_range(12));
		if ($urandom_range(9) == 0)
			r.quantity = $urandom_range(1) ? '1 : '0;
		if ($urandom_range(4) != 0)
			r.depth = 5'($urandom_range(6));
		if (r.action == ACT_ADD)
			used_ids = {used_ids, r.order_id};
		return r;
	endfunction

	row_t rows[$];

	initial begin
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
		rows = '{
			'{mk(ACT_RD_BID, 0, 0, 0, 0, 5'd4), 1, ST_EMPTY},
			'{mk(ACT_RD_ASK, 0, 1, 0, 0, 5'd0), 1, ST_EMPTY},
			'{mk(ACT_RM_BID, 0, 0, 0, 0, 0), 1, ST_EMPTY},
			'{mk(ACT_RM_ASK, 0, 1, 0, 0, 0), 1, ST_EMPTY},
			'{mk(ACT_CANCEL, 32'd7, 0, 0, 0, 0), 1, ST_NOT_FOUND},
			'{mk(ACT_ADD, 32'd0, 0, 20'd0, 24'd0, 0), 1, ST_OK},
			'{mk(ACT_ADD, '1, 0, '1, '1, '1), 1, ST_OK},
			'{mk(ACT_ADD, '1, 1, 20'd5, 24'd3, 0), 1, ST_DUP},
			'{mk(ACT_ADD, 32'd10, 1, 20'd100, 24'd9, 0), 0, 0},
			'{mk(ACT_ADD, 32'd11, 1, 20'd50, 24'd4, 0), 0, 0},
			'{mk(ACT_ADD, 32'd12, 0, 20'd10, 24'd6, 0), 0, 0},
			'{mk(ACT_ADD, 32'd13, 0, 20'd10, 24'd8, 0), 0, 0},
			'{mk(ACT_ADD, 32'd14, 0, 20'd10, 24'd2, 0), 0, 0},
			'{mk(ACT_RD_BID, 0, 0, 0, 0, 5'd0), 1, ST_OK},
			'{mk(ACT_RD_BID, 0, 0, 0, 0, 5'd31), 0, 0},
			'{mk(ACT_RD_ASK, 0, 1, 0, 0, 5'd1), 0, 0},
			'{mk(ACT_CANCEL, 32'd13, 0, 0, 0, 0), 1, ST_OK},
			'{mk(ACT_SPARE6, 32'd12, 1, '1, '1, '1), 1, ST_OK},
			'{mk(ACT_SPARE7, 0, 0, 0, 0, 0), 1, ST_OK},
			'{mk(ACT_RM_BID, 0, 0, 0, 0, 0), 1, ST_OK},
			'{mk(ACT_CANCEL, '1, 0, 0, 0, 0), 1, ST_NOT_FOUND},
			'{mk(ACT_RM_ASK, 0, 1, 0, 0, 0), 1, ST_OK},
			'{mk(ACT_RD_BID, 0, 0, 0, 0, 5'd16), 0, 0},
			'{mk(ACT_RD_ASK, 0, 1, 0, 0, 5'd17), 0, 0}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		foreach (rows[i])
			send_word(rows[i].word, rows[i].typed, rows[i].st);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3) begin
				tx_idle = 52;
				rx_idle = 19;
			end else if (n == 2 * N_RANDOM / 3) begin
				tx_idle = 0;
				rx_idle = 0;
			end
			send_word(random_word(), 1'b0, 3'd0);
		end
		req_if.valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0 && expected_rsp.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
